// ----- rtl/core/sgs_pkg.sv -----
// Package for the scan gap segmenter: field widths, register codes and reset
// values, and the section record types shared by the core modules.
// No dependencies.
package sgs_pkg;

  localparam int unsigned COORD_W    = 16;  // point coordinate, two's complement
  localparam int unsigned SEC_IDX_W  = 10;  // index width on the result port
  localparam int unsigned SPAN_W     = 10;  // min_span register
  localparam int unsigned GAP_W      = 16;  // gap_mm register
  localparam int unsigned GAP_SQ_W   = 2 * GAP_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MM   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN = 1'd1;

  // Reset values: gap of 300 mm (kept squared), min span of 5
  localparam logic [GAP_SQ_W-1:0] GAP_SQ_RST   = 32'd90000;
  localparam logic [SPAN_W-1:0]   MIN_SPAN_RST = 10'd5;

  typedef struct packed {
    logic [SEC_IDX_W-1:0] first_idx;
    logic [SEC_IDX_W-1:0] last_idx;
    logic                 done;
  } sgs_section_t;

  // Up to two sections leave per point: a gap-closed one, then the final one.
  typedef struct packed {
    logic         v0;
    logic         v1;
    sgs_section_t s0;
    sgs_section_t s1;
  } sgs_push_t;

endpackage

// ----- rtl/core/scan_gap_segmenter_unit.sv -----
// Top level of the scan gap segmenter: input register, config registers,
// gap test, section tracker and result queue. Depends on sgs_pkg and the
// sgs_gap_test, sgs_section_ctrl and sgs_result_fifo modules.
//
//   channel   | direction | handshake                      | payload
//   ----------+-----------+--------------------------------+-------------------------------
//   point     | in        | point_valid_i / point_ready_o  | point_x_i, point_y_i, last_point_i
//   section   | out       | section_valid_o / section_ready_i | section_first_o, section_final_o,
//             |           |                                | scan_done_o
//   config    | in        | cfg_we_i (no wait)             | cfg_idx_i, cfg_data_i
//
// One point beat per cycle while the output keeps up. A point is processed
// straight out of the input register and its sections are registered into a
// 4-entry result queue, from which they leave one per output beat.
// A point may make two sections, so with a stalled or slow output the queue
// fills and point_ready_o drops until it has room for two records again.
// point_ready_o does not depend combinationally on section_ready_i.
// Reset (rst_ni low, async) empties the queue, restarts the scan at index 0
// and loads gap_mm = 300 and min_span = 5.
module scan_gap_segmenter_unit #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // points
  input  logic                           point_valid_i,
  output logic                           point_ready_o,
  input  logic [sgs_pkg::COORD_W-1:0]    point_x_i,
  input  logic [sgs_pkg::COORD_W-1:0]    point_y_i,
  input  logic                           last_point_i,
  // sections
  output logic                           section_valid_o,
  input  logic                           section_ready_i,
  output logic [sgs_pkg::SEC_IDX_W-1:0]  section_first_o,
  output logic [sgs_pkg::SEC_IDX_W-1:0]  section_final_o,
  output logic                           scan_done_o
);
  import sgs_pkg::*;

  // Config: the gap is kept squared, squared right at the write
  logic [GAP_SQ_W-1:0] gap_sq_q;
  logic [GAP_SQ_W-1:0] gap_sq_new;
  logic [SPAN_W-1:0]   min_span_q;

  assign gap_sq_new = GAP_SQ_W'(cfg_data_i) * GAP_SQ_W'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_sq_q   <= GAP_SQ_RST;
      min_span_q <= MIN_SPAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAP_MM:   gap_sq_q   <= gap_sq_new;
        CFG_MIN_SPAN: min_span_q <= cfg_data_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic               in_valid_q;
  logic [COORD_W-1:0] in_x_q, in_y_q;
  logic               in_last_q;
  logic               fire;
  logic               room;

  assign fire          = in_valid_q && room;
  assign point_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (point_ready_o) begin
      in_valid_q <= point_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (point_ready_o && point_valid_i) begin
      in_x_q    <= point_x_i;
      in_y_q    <= point_y_i;
      in_last_q <= last_point_i;
    end
  end

  // Gap test against the previous point
  logic [COORD_W-1:0] prev_x, prev_y;
  logic               is_gap;

  sgs_gap_test u_gap_test (
    .cur_x_i  (in_x_q),
    .cur_y_i  (in_y_q),
    .prev_x_i (prev_x),
    .prev_y_i (prev_y),
    .gap_sq_i (gap_sq_q),
    .is_gap_o (is_gap)
  );

  // Section bookkeeping
  sgs_push_t push;

  sgs_section_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_section_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cur_x_i    (in_x_q),
    .cur_y_i    (in_y_q),
    .cur_last_i (in_last_q),
    .is_gap_i   (is_gap),
    .min_span_i (min_span_q),
    .prev_x_o   (prev_x),
    .prev_y_o   (prev_y),
    .push_o     (push)
  );

  // Result queue, output side
  sgs_section_t head;

  sgs_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (section_valid_o),
    .ready_i (section_ready_i),
    .head_o  (head)
  );

  assign section_first_o = head.first_idx;
  assign section_final_o = head.last_idx;
  assign scan_done_o     = head.done;

endmodule

// ----- rtl/core/sgs_gap_test.sv -----
// Gap test: squared distance between two points against the squared gap.
// Depends on sgs_pkg.
module sgs_gap_test (
  input  logic [sgs_pkg::COORD_W-1:0]  cur_x_i,
  input  logic [sgs_pkg::COORD_W-1:0]  cur_y_i,
  input  logic [sgs_pkg::COORD_W-1:0]  prev_x_i,
  input  logic [sgs_pkg::COORD_W-1:0]  prev_y_i,
  input  logic [sgs_pkg::GAP_SQ_W-1:0] gap_sq_i,
  output logic                         is_gap_o
);
  import sgs_pkg::*;

  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * COORD_W;
  localparam int unsigned SUM_W  = SQ_W + 1;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [DIFF_W-1:0] dx_neg, dy_neg;
  logic        [COORD_W-1:0] ux, uy;
  logic        [SQ_W-1:0]    sq_x, sq_y;
  logic        [SUM_W-1:0]   dist_sq;

  assign dx = DIFF_W'(signed'(cur_x_i)) - DIFF_W'(signed'(prev_x_i));
  assign dy = DIFF_W'(signed'(cur_y_i)) - DIFF_W'(signed'(prev_y_i));
  assign dx_neg = -dx;
  assign dy_neg = -dy;

  // |d| never exceeds 65535, so it fits in COORD_W bits
  assign ux = dx[DIFF_W-1] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
  assign uy = dy[DIFF_W-1] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];

  assign sq_x    = SQ_W'(ux) * SQ_W'(ux);
  assign sq_y    = SQ_W'(uy) * SQ_W'(uy);
  assign dist_sq = SUM_W'(sq_x) + SUM_W'(sq_y);

  // Equal to the threshold is not a gap
  assign is_gap_o = dist_sq > SUM_W'(gap_sq_i);

endmodule

// ----- rtl/core/sgs_section_ctrl.sv -----
// Section tracker: point index, open section start and previous point;
// turns each point into zero, one or two section records.
// Depends on sgs_pkg.
module sgs_section_ctrl #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [sgs_pkg::COORD_W-1:0] cur_x_i,
  input  logic [sgs_pkg::COORD_W-1:0] cur_y_i,
  input  logic                        cur_last_i,
  input  logic                        is_gap_i,
  input  logic [sgs_pkg::SPAN_W-1:0]  min_span_i,
  output logic [sgs_pkg::COORD_W-1:0] prev_x_o,
  output logic [sgs_pkg::COORD_W-1:0] prev_y_o,
  output sgs_pkg::sgs_push_t          push_o
);
  import sgs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CMP_W = (IDX_W > SPAN_W) ? IDX_W : SPAN_W;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_POINTS - 1);

  logic [COORD_W-1:0] prev_x_q, prev_y_q;
  logic [IDX_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   open_q, open_d;

  logic             gap;
  logic             keep;
  logic             is_final;
  logic [IDX_W-1:0] end_idx;
  logic [IDX_W-1:0] span;
  logic [IDX_W-1:0] start_after;
  sgs_section_t     gap_sec, final_sec;

  // No distance test on the first point of a scan
  assign gap         = is_gap_i && (count_q != '0);
  assign end_idx     = count_q - IDX_W'(1);
  assign span        = end_idx - open_q;
  assign keep        = gap && (CMP_W'(span) >= CMP_W'(min_span_i));
  assign start_after = gap ? count_q : open_q;
  // Scan length limit forces the end of a scan
  assign is_final    = cur_last_i || (count_q == IDX_MAX);

  always_comb begin
    gap_sec.first_idx   = SEC_IDX_W'(open_q);
    gap_sec.last_idx    = SEC_IDX_W'(end_idx);
    gap_sec.done        = 1'b0;
    final_sec.first_idx = SEC_IDX_W'(start_after);
    final_sec.last_idx  = SEC_IDX_W'(count_q);
    final_sec.done      = 1'b1;

    push_o.v0 = fire_i && (keep || is_final);
    push_o.v1 = fire_i && keep && is_final;
    push_o.s0 = keep ? gap_sec : final_sec;
    push_o.s1 = final_sec;

    if (is_final) begin
      count_d = '0;
      open_d  = '0;
    end else begin
      count_d = count_q + IDX_W'(1);
      open_d  = start_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      count_q  <= '0;
      open_q   <= '0;
    end else if (fire_i) begin
      prev_x_q <= cur_x_i;
      prev_y_q <= cur_y_i;
      count_q  <= count_d;
      open_q   <= open_d;
    end
  end

  assign prev_x_o = prev_x_q;
  assign prev_y_o = prev_y_q;

endmodule

// ----- rtl/core/sgs_result_fifo.sv -----
// Result queue: small register FIFO that takes up to two section records a
// cycle and hands out one per output beat. Depends on sgs_pkg.
module sgs_result_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sgs_pkg::sgs_push_t   push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output sgs_pkg::sgs_section_t head_o
);
  import sgs_pkg::*;

  sgs_section_t          mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic                  pop;
  logic [1:0]            n_push;

  assign valid_o    = count_q != '0;
  assign pop        = valid_o && ready_i;
  // Room for a worst-case point (two records), judged on the registered count
  assign room_o     = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign wr_ptr_nxt = wr_ptr_q + FIFO_PTR_W'(1);
  assign n_push     = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(n_push);
    rd_ptr_d = pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.s0;
    end
    if (push_i.v1) begin
      mem_q[wr_ptr_nxt] <= push_i.s1;
    end
  end

endmodule

// ----- tb/tb_scan_gap_segmenter_unit.sv -----
// Self-checking testbench for scan_gap_segmenter_unit: directed scans around the gap and span
// limits, one over-long scan, then random scans under random back-pressure on both sides.
// Depends on sgs_pkg and the scan_gap_segmenter_unit RTL.
module tb_scan_gap_segmenter_unit;
  import sgs_pkg::*;

  localparam int unsigned MAX_PTS       = 1024;
  localparam int unsigned RANDOM_POINTS = 680;
  localparam int unsigned PHASE_POINTS  = 170;
  // Input register plus the processing cycle, with margin: a point that closes
  // nothing may still be in flight after the last expected section has left.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = CFG_GAP_MM;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  point_valid = 1'b0;
  logic [COORD_W-1:0]    point_x     = '0;
  logic [COORD_W-1:0]    point_y     = '0;
  logic                  point_last  = 1'b0;
  logic                  section_ready = 1'b0;

  logic                  point_ready_o;
  logic                  section_valid_o;
  logic [SEC_IDX_W-1:0]  section_first_o;
  logic [SEC_IDX_W-1:0]  section_final_o;
  logic                  scan_done_o;

  scan_gap_segmenter_unit #(
    .MAX_POINTS(MAX_PTS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .point_valid_i  (point_valid),
    .point_ready_o  (point_ready_o),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .last_point_i   (point_last),
    .section_valid_o(section_valid_o),
    .section_ready_i(section_ready),
    .section_first_o(section_first_o),
    .section_final_o(section_final_o),
    .scan_done_o    (scan_done_o)
  );

  // 12-unit clock, high half first
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Segmenter shadow: register copies, scan state, and the sections still owed
  // ---------------------------------------------------------------------------
  logic [GAP_W-1:0]        gap_cfg  = 16'd300;
  logic [SPAN_W-1:0]       span_cfg = MIN_SPAN_RST;
  logic signed [COORD_W-1:0] prev_px = '0;
  logic signed [COORD_W-1:0] prev_py = '0;
  int unsigned             scan_idx   = 0;  // index the next point gets
  int unsigned             open_first = 0;  // first index of the open section
  sgs_section_t            owed_sections[$];

  bit          idle_on = 1'b0;  // random bursts of idling on both sides
  int unsigned err_count     = 0;
  int unsigned points_sent   = 0;
  int unsigned scans_closed  = 0;
  int unsigned sections_seen = 0;
  int unsigned reg_writes    = 0;
  int unsigned cycle_count   = 0;
  int unsigned ready_hold    = 0;
  sgs_section_t got_sec;
  sgs_section_t want_sec;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    err_count++;
  endtask

  // Advance the shadow by one accepted point beat and queue the sections it closes.
  function automatic void segment_point(input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic last);
    longint       dx;
    longint       dy;
    longint       dist_sq;
    longint       gap_sq;
    int unsigned  idx;
    sgs_section_t sec;
    idx = scan_idx;
    // The first point of a scan has no neighbor to measure against.
    if (idx > 0) begin
      dx      = longint'(x) - longint'(prev_px);
      dy      = longint'(y) - longint'(prev_py);
      dist_sq = dx * dx + dy * dy;
      gap_sq  = longint'(gap_cfg) * longint'(gap_cfg);
      // Strictly greater: a distance exactly at the threshold keeps the section open.
      if (dist_sq > gap_sq) begin
        if ((idx - 1) - open_first >= span_cfg) begin
          sec.first_idx = SEC_IDX_W'(open_first);
          sec.last_idx  = SEC_IDX_W'(idx - 1);
          sec.done      = 1'b0;
          owed_sections = {owed_sections, sec};
        end
        open_first = idx;
      end
    end
    prev_px = x;
    prev_py = y;
    // The final section skips the span check; an over-long scan ends on its own.
    if (last || idx >= MAX_PTS - 1) begin
      sec.first_idx = SEC_IDX_W'(open_first);
      sec.last_idx  = SEC_IDX_W'(idx);
      sec.done      = 1'b1;
      owed_sections = {owed_sections, sec};
      scan_idx   = 0;
      open_first = 0;
      scans_closed++;
    end else begin
      scan_idx = idx + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Point side: one beat per call, driven at the falling edge, accepted at the
  // rising edge. Valid stays up between back-to-back beats.
  // ---------------------------------------------------------------------------
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic last);
    int unsigned gap_cycles;
    gap_cycles = 0;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) gap_cycles = $urandom_range(1, 15);
    if (gap_cycles > 0) begin
      point_valid <= 1'b0;
      repeat (gap_cycles) @(negedge clk);
    end
    point_valid <= 1'b1;
    point_x     <= x;
    point_y     <= y;
    point_last  <= last;
    forever begin
      @(posedge clk);
      if (point_ready_o) break;
    end
    segment_point(x, y, last);
    points_sent++;
  endtask

  // Hold the point side until every owed section has left, then let the pipe settle.
  task automatic wait_sections_out();
    @(negedge clk);
    point_valid <= 1'b0;
    while (owed_sections.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_sections_out();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GAP_MM) gap_cfg = GAP_W'(value);
    else span_cfg = SPAN_W'(value);
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Section side: random stall bursts, and the checker at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!idle_on) begin
      section_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      section_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      ready_hold = $urandom_range(0, 14);
      section_ready <= 1'b0;
    end else begin
      section_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && section_valid_o && section_ready) begin
      got_sec.first_idx = section_first_o;
      got_sec.last_idx  = section_final_o;
      got_sec.done      = scan_done_o;
      if (owed_sections.size() == 0) begin
        report_mismatch($sformatf("section [%0d,%0d] done=%0b with none owed",
                                  got_sec.first_idx, got_sec.last_idx, got_sec.done));
      end else begin
        want_sec = owed_sections.pop_front();
        if (got_sec.first_idx !== want_sec.first_idx)
          report_mismatch($sformatf("section_first %0d, want %0d",
                                    got_sec.first_idx, want_sec.first_idx));
        if (got_sec.last_idx !== want_sec.last_idx)
          report_mismatch($sformatf("section_final %0d, want %0d",
                                    got_sec.last_idx, want_sec.last_idx));
        if (got_sec.done !== want_sec.done)
          report_mismatch($sformatf("scan_done %0b, want %0b", got_sec.done, want_sec.done));
      end
      sections_seen++;
    end
  end

  // Watchdog: a lost section or a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sections still owed",
               cycle_count, owed_sections.size());
      $display("scan_gap_segmenter_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values (gap 300 mm, span 5): single-point scan, threshold hit exactly,
  // short sections dropped, extreme coordinates.
  task automatic test_reset_config();
    send_point(16'sd0, 16'sd0, 1'b1);           // single-point scan -> [0,0] done
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd300, 16'sd0, 1'b0);         // exactly 300 on one axis: no break
    send_point(16'sd480, 16'sd240, 1'b0);       // 180/240 step, exactly 300: no break
    send_point(16'sd781, 16'sd240, 1'b0);       // 301: break, [0,2] too short
    send_point(-16'sd32768, -16'sd32768, 1'b0); // break, [3,3] dropped
    send_point(16'sd32767, 16'sd32767, 1'b0);   // largest possible jump
    send_point(16'sd32767, -16'sd32768, 1'b1);  // break and scan end in one beat
  endtask

  // Zero and full-scale thresholds.
  task automatic test_threshold_edges();
    write_reg(CFG_GAP_MM, 0);
    write_reg(CFG_MIN_SPAN, 0);                 // every closed section kept
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b0);           // same point: zero distance is no gap
    send_point(16'sd5, 16'sd6, 1'b0);           // -> [0,1]
    send_point(-16'sd1, -16'sd1, 1'b1);         // -> [2,2] then [3,3] done
    write_reg(CFG_GAP_MM, 65535);
    write_reg(CFG_MIN_SPAN, 1);
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);   // diagonal beats 65535: [0,0] dropped
    send_point(16'sd32767, -16'sd32768, 1'b0);  // exactly 65535: no break
    send_point(16'sd0, 16'sd0, 1'b1);
  endtask

  // Span boundary: kept at exactly min_span, dropped just below; largest span drops all.
  task automatic test_span_limits();
    write_reg(CFG_GAP_MM, 10);
    write_reg(CFG_MIN_SPAN, 3);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd5, 16'sd0, 1'b0);
    send_point(16'sd10, 16'sd0, 1'b0);
    send_point(16'sd15, 16'sd0, 1'b0);
    send_point(16'sd100, 16'sd0, 1'b0);         // [0,3] kept, span exactly 3
    send_point(16'sd105, 16'sd0, 1'b0);
    send_point(16'sd200, 16'sd0, 1'b0);         // [4,5] dropped
    write_reg(CFG_MIN_SPAN, 1023);              // scan state carries across the write
    send_point(16'sd205, 16'sd0, 1'b0);
    send_point(-16'sd300, 16'sd0, 1'b1);        // [6,7] dropped, final [8,8]
  endtask

  // A scan that never raises last_point is cut at MAX_POINTS-1 and restarts at 0.
  task automatic test_scan_overflow();
    int wx;
    int wy;
    write_reg(CFG_GAP_MM, 50);
    write_reg(CFG_MIN_SPAN, 20);
    wx = 0;
    wy = 0;
    for (int i = 0; i < MAX_PTS + 20; i++) begin
      if ($urandom_range(0, 39) == 0) wx += 200;
      else begin
        wx += int'($urandom_range(0, 60)) - 30;
        wy += int'($urandom_range(0, 60)) - 30;
      end
      send_point(COORD_W'(wx), COORD_W'(wy), i == MAX_PTS + 19);
    end
  endtask

  // Random scans: mostly walks with steps inside the gap, some exactly on it,
  // some just over it, big jumps and full-range noise. Settings change per phase.
  task automatic test_random_scans();
    int          wx;
    int          wy;
    int          dx;
    int          dy;
    int unsigned g;
    int unsigned scan_len;
    int unsigned done_points;
    int unsigned phase_end;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    done_points = 0;
    while (done_points < RANDOM_POINTS) begin
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_GAP_MM, 0);
        1:       write_reg(CFG_GAP_MM, 1);
        2:       write_reg(CFG_GAP_MM, 300);
        3:       write_reg(CFG_GAP_MM, 65535);
        4:       write_reg(CFG_GAP_MM, $urandom_range(2, 2000));
        default: write_reg(CFG_GAP_MM, $urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_MIN_SPAN, 0);
        1:       write_reg(CFG_MIN_SPAN, 1);
        2:       write_reg(CFG_MIN_SPAN, 5);
        3:       write_reg(CFG_MIN_SPAN, 1023);
        4:       write_reg(CFG_MIN_SPAN, $urandom_range(0, 30));
        default: write_reg(CFG_MIN_SPAN, $urandom_range(0, 1023));
      endcase
      // The closing phase runs with no idling at all.
      idle_on   = (done_points + PHASE_POINTS < RANDOM_POINTS) && ($urandom_range(0, 3) != 0);
      phase_end = done_points + PHASE_POINTS;
      g         = gap_cfg;
      while (done_points < phase_end && done_points < RANDOM_POINTS) begin
        scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                               : $urandom_range(1, 40);
        if (scan_len > RANDOM_POINTS - done_points) scan_len = RANDOM_POINTS - done_points;
        wx = int'($urandom_range(0, 65535)) - 32768;
        wy = int'($urandom_range(0, 65535)) - 32768;
        for (int unsigned i = 0; i < scan_len; i++) begin
          if (i > 0) begin
            case ($urandom_range(0, 9))
              6: begin  // on the threshold
                if (g % 5 == 0) begin
                  dx = g * 3 / 5;
                  dy = g * 4 / 5;
                end else begin
                  dx = g;
                  dy = 0;
                end
              end
              7: begin  // just over it
                dx = g + 1 + $urandom_range(0, 3);
                dy = $urandom_range(0, 2);
              end
              8: begin  // big jump
                dx = $urandom_range(0, 65535);
                dy = $urandom_range(0, 65535);
              end
              9: begin  // noise point anywhere
                dx = 0;
                dy = 0;
                wx = int'($urandom_range(0, 65535)) - 32768;
                wy = int'($urandom_range(0, 65535)) - 32768;
              end
              default: begin  // small step inside the gap
                dx = $urandom_range(0, g * 7 / 10);
                dy = $urandom_range(0, g * 7 / 10);
              end
            endcase
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            wx += dx;
            wy += dy;
          end
          px = COORD_W'(wx);
          py = COORD_W'(wy);
          // keep the walk in the 16-bit coordinate range, wrapping like the port does
          wx = int'($signed(px));
          wy = int'($signed(py));
          send_point(px, py, i == scan_len - 1);
          done_points++;
        end
        // Now and then let the output run dry before the next scan.
        if ($urandom_range(0, 15) == 0) wait_sections_out();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    test_reset_config();
    test_threshold_edges();
    test_span_limits();
    test_scan_overflow();
    test_random_scans();

    idle_on = 1'b0;
    wait_sections_out();
    $display("ran %0d points in %0d scans through %0d register writes; %0d sections checked",
             points_sent, scans_closed, reg_writes, sections_seen);
    $display("gap and span extremes, exact-threshold steps, over-long scan, random stalls");
    if (err_count == 0) begin
      $display("scan_gap_segmenter_unit: match");
    end else begin
      $display("%0d mismatches", err_count);
      $display("scan_gap_segmenter_unit: mismatch");
    end
    $finish;
  end

endmodule
